FILE: rtl/sgr_pkg.sv
// Shared types, character codes and colour table for the SGR colour parser.
package sgr_pkg;

    localparam logic [23:0] WHITE = 24'hFFFFFF;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [31:0] SGR_FG_FIRST = 32'd30;
    localparam logic [31:0] SGR_FG_LAST  = 32'd39;

    localparam int PALETTE_DEPTH = 10;
    localparam logic [23:0] PALETTE [PALETTE_DEPTH] = '{
        24'h000000, 24'hFF7777, 24'h77FF77, 24'hFFF93F, 24'h7777FF,
        24'hC300FF, 24'h00FFEA, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF
    };

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_LIST = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_text;
    } sgr_in_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [23:0] color_out;
        logic        last_in_run;
    } sgr_out_t;

    // Results of one input byte: up to two beats, in order
    typedef struct packed {
        logic [1:0] count;
        sgr_out_t   beat0;
        sgr_out_t   beat1;
    } sgr_res_t;

    // Fold one finished number into the colour being built
    function automatic logic [23:0] sgr_apply(input logic [31:0] value,
                                              input logic [23:0] pending);
        logic [31:0] offset;
        logic [23:0] color;
        offset = value - SGR_FG_FIRST;
        color  = pending;
        if (value >= SGR_FG_FIRST && value <= SGR_FG_LAST)
        begin
            color = PALETTE[offset[3:0]];
        end
        if (value == 32'd0)
        begin
            color = WHITE;
        end
        return color;
    endfunction

endpackage

FILE: rtl/ansi_sgr_color_parser.sv
// A taken byte is held in the input register; its beats are offered from the buffer.
// Throughput: one byte per cycle while results are taken and each byte yields at most
// one beat; after an ESC, a byte other than '[' or ESC yields two beats.
// Limit: the two-slot result buffer takes a byte only when all its beats fit.
// Reset: clears the input and result buffers, returns to text mode with white colours.
// Top level: input register, parser and result buffer of the SGR colour parser.
module ansi_sgr_color_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  sgr_pkg::sgr_in_t  src_data,
    output logic              res_valid,
    input  logic              res_ready,
    output sgr_pkg::sgr_out_t res_data
);

    logic              in_valid_reg, in_valid_next;
    sgr_pkg::sgr_in_t  in_data_reg;
    sgr_pkg::sgr_res_t parsed;
    logic [1:0]        fill;
    logic              advance;
    logic              take;

    // process the held byte when its beats fit in the buffer as it stands
    assign advance   = in_valid_reg
                       && (({1'b0, fill} + {1'b0, parsed.count}) <= 3'd2);
    assign src_ready = !in_valid_reg || advance;
    assign take      = src_valid && src_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= src_data;
        end
    end

    sgr_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_data_reg),
        .res   (parsed)
    );

    sgr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (parsed),
        .push_en   (advance),
        .fill      (fill),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

FILE: rtl/sgr_parser.sv
// Escape sequence parser: mode, colour and number state, and per-byte results.
module sgr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  sgr_pkg::sgr_in_t  item,
    output sgr_pkg::sgr_res_t res
);

    sgr_pkg::mode_t mode_reg, mode_next;
    logic [23:0]    current_reg, current_next;
    logic [23:0]    pending_reg, pending_next;
    logic [31:0]    value_reg, value_next;
    logic           has_digit_reg, has_digit_next;
    logic           overflow_reg, overflow_next;

    logic [7:0]  b;
    logic        is_digit;
    logic [7:0]  digit_byte;
    logic [35:0] product;
    logic        number_ok;
    logic [23:0] applied;

    assign b          = item.byte_in;
    assign is_digit   = (b >= sgr_pkg::CH_ZERO) && (b <= sgr_pkg::CH_NINE);
    assign digit_byte = b - sgr_pkg::CH_ZERO;
    // value * 10 + digit as (value << 3) + (value << 1) + digit
    assign product    = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0}
                        + {32'd0, digit_byte[3:0]};
    assign number_ok  = has_digit_reg && !overflow_reg;
    assign applied    = sgr_pkg::sgr_apply(value_reg, pending_reg);

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            sgr_pkg::MODE_LIST:
            begin
                if (!is_digit && !(number_ok && b == sgr_pkg::CH_SEMI))
                begin
                    mode_next = sgr_pkg::MODE_TEXT;
                end
            end
            sgr_pkg::MODE_ESC:
            begin
                if (b == sgr_pkg::CH_LBRACK)
                begin
                    mode_next = sgr_pkg::MODE_LIST;
                end
                else if (b == sgr_pkg::CH_ESC)
                begin
                    mode_next = sgr_pkg::MODE_ESC;
                end
                else
                begin
                    mode_next = sgr_pkg::MODE_TEXT;
                end
            end
            sgr_pkg::MODE_TEXT:
            begin
                if (b == sgr_pkg::CH_ESC)
                begin
                    mode_next = sgr_pkg::MODE_ESC;
                end
            end
            default:
            begin
                mode_next = sgr_pkg::MODE_TEXT;
            end
        endcase
        if (item.end_of_text)
        begin
            mode_next = sgr_pkg::MODE_TEXT;
        end
    end

    // Colour and number datapath
    always_comb
    begin
        current_next   = current_reg;
        pending_next   = pending_reg;
        value_next     = value_reg;
        has_digit_next = has_digit_reg;
        overflow_next  = overflow_reg;
        case (mode_reg)
            sgr_pkg::MODE_LIST:
            begin
                if (is_digit)
                begin
                    value_next     = product[31:0];
                    has_digit_next = 1'b1;
                    if (product[35:32] != 4'd0)
                    begin
                        overflow_next = 1'b1;
                    end
                end
                else if (number_ok && b == sgr_pkg::CH_SEMI)
                begin
                    pending_next   = applied;
                    value_next     = 32'd0;
                    has_digit_next = 1'b0;
                    overflow_next  = 1'b0;
                end
                else if (number_ok && b == sgr_pkg::CH_M)
                begin
                    pending_next = applied;
                    current_next = applied;
                end
            end
            sgr_pkg::MODE_ESC:
            begin
                if (b == sgr_pkg::CH_LBRACK)
                begin
                    pending_next   = current_reg;
                    value_next     = 32'd0;
                    has_digit_next = 1'b0;
                    overflow_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (item.end_of_text)
        begin
            current_next   = sgr_pkg::WHITE;
            pending_next   = sgr_pkg::WHITE;
            value_next     = 32'd0;
            has_digit_next = 1'b0;
            overflow_next  = 1'b0;
        end
    end

    // Result beats for this byte
    always_comb
    begin
        res                   = '0;
        res.beat0.color_out   = current_reg;
        res.beat1.color_out   = current_reg;
        case (mode_reg)
            sgr_pkg::MODE_ESC:
            begin
                if (b != sgr_pkg::CH_LBRACK)
                begin
                    // emit the held ESC, then the byte unless it opens a new escape
                    res.beat0.char_out = sgr_pkg::CH_ESC;
                    if (b == sgr_pkg::CH_ESC)
                    begin
                        res.count             = 2'd1;
                        res.beat0.last_in_run = 1'b1;
                    end
                    else
                    begin
                        res.count             = 2'd2;
                        res.beat1.char_out    = b;
                        res.beat1.last_in_run = 1'b1;
                    end
                end
            end
            sgr_pkg::MODE_TEXT:
            begin
                if (b != sgr_pkg::CH_ESC)
                begin
                    res.count             = 2'd1;
                    res.beat0.char_out    = b;
                    res.beat0.last_in_run = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sgr_pkg::MODE_TEXT;
            current_reg   <= sgr_pkg::WHITE;
            pending_reg   <= sgr_pkg::WHITE;
            value_reg     <= 32'd0;
            has_digit_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            current_reg   <= current_next;
            pending_reg   <= pending_next;
            value_reg     <= value_next;
            has_digit_reg <= has_digit_next;
            overflow_reg  <= overflow_next;
        end
    end

`ifndef SYNTH
    a_list_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sgr_pkg::MODE_LIST) |-> (res.count == 2'd0))
        else $error("parser emitted a beat inside a parameter list");

    a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.end_of_text) |=>
            (mode_reg == sgr_pkg::MODE_TEXT && current_reg == sgr_pkg::WHITE
             && pending_reg == sgr_pkg::WHITE && !has_digit_reg))
        else $error("state not cleared after end of text");
`endif

endmodule

FILE: rtl/sgr_out_buf.sv
// Two-beat result buffer in front of the output channel.
module sgr_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  sgr_pkg::sgr_res_t  push,
    input  logic               push_en,
    output logic [1:0]         fill,
    output logic               res_valid,
    input  logic               res_ready,
    output sgr_pkg::sgr_out_t  res_data
);

    sgr_pkg::sgr_out_t slot0_reg, slot0_next;
    sgr_pkg::sgr_out_t slot1_reg, slot1_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        push_cnt;
    logic [1:0]        keep_cnt;
    logic              pop;

    assign pop       = res_valid && res_ready;
    assign push_cnt  = push_en ? push.count : 2'd0;
    assign fill      = cnt_reg;
    assign res_valid = (cnt_reg != 2'd0);
    assign res_data  = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        keep_cnt   = cnt_reg;
        // advance the queue on a taken beat
        if (pop)
        begin
            slot0_next = slot1_reg;
            keep_cnt   = cnt_reg - 2'd1;
        end
        if (push_cnt != 2'd0)
        begin
            if (keep_cnt == 2'd0)
            begin
                slot0_next = push.beat0;
                slot1_next = push.beat1;
            end
            else
            begin
                slot1_next = push.beat0;
            end
        end
        cnt_next = keep_cnt + push_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`ifndef SYNTH
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result buffer fill out of range");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> (({1'b0, cnt_reg} + {1'b0, push_cnt}) <= 3'd2))
        else $error("result buffer pushed beyond its room");
`endif

endmodule
